// ----- sv/nsc_pkg.sv -----
// Shared constants and the letter lookup for the notation symbol counter.
package nsc_pkg;

    localparam int NumCounters       = 23;
    localparam int CountWidthDefault = 16;
    localparam int IdxWidth          = 5;
    localparam int ValueWidth        = 16;

    // Counter positions after the 19 letter symbols.
    localparam logic [IdxWidth-1:0] IDX_CHAINS = 5'd19;
    localparam logic [IdxWidth-1:0] IDX_UNSAT  = 5'd20;
    localparam logic [IdxWidth-1:0] IDX_OTHER  = 5'd21;
    localparam logic [IdxWidth-1:0] IDX_SCAFF  = 5'd22;
    localparam logic [IdxWidth-1:0] CODE_NONE  = 5'd30;
    localparam logic [IdxWidth-1:0] CODE_RING  = 5'd31;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_J     = 8'h4A;
    localparam logic [7:0] CHAR_L     = 8'h4C;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_Z     = 8'h5A;

    // Maps an upper-case letter other than J to its counter index, CODE_RING or CODE_NONE.
    function automatic logic [IdxWidth-1:0] letter_code(input logic [7:0] c);
        logic [IdxWidth-1:0] code;
        case (c)
            8'h42:   code = 5'd0;   // B
            8'h50:   code = 5'd1;   // P
            8'h53:   code = 5'd2;   // S
            8'h4B:   code = 5'd3;   // K
            8'h4D:   code = 5'd4;   // M
            8'h4E:   code = 5'd5;   // N
            8'h5A:   code = 5'd6;   // Z
            8'h59:   code = 5'd7;   // Y
            8'h58:   code = 5'd8;   // X
            8'h4F:   code = 5'd9;   // O
            8'h51:   code = 5'd10;  // Q
            8'h45:   code = 5'd11;  // E
            8'h46:   code = 5'd12;  // F
            8'h47:   code = 5'd13;  // G
            8'h48:   code = 5'd14;  // H
            8'h49:   code = 5'd15;  // I
            8'h56:   code = 5'd16;  // V
            8'h57:   code = 5'd17;  // W
            8'h52:   code = 5'd18;  // R
            8'h55:   code = IDX_UNSAT;
            CHAR_L:  code = CODE_RING;
            CHAR_T:  code = CODE_RING;
            default: code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

// ----- sv/notation_symbol_counter_top.sv -----
// Notation symbol counter: per-character parse flags, 23 saturating counters, serial dump.
// A character item updates the state in the cycle after it is accepted; an
// end-of-string item passes through the input register and snapshot bank to the output.
// Throughput: one item in per cycle; 23 results per end item, one per cycle unless stalled.
// A second end item waits in the input register until the snapshot bank has handed its
// previous run into the output register. Reset (synchronous, active low) clears flags,
// counters and handshake state; the snapshot bank needs no reset.
module notation_symbol_counter_top
    import nsc_pkg::*;
#(
    parameter int COUNT_WIDTH = CountWidthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol_char
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [4:0] counter_index, [20:5] count_value, rest zero
    output logic        m_axis_tlast,   // last
    output logic        m_axis_tuser    // bad_character
);

    localparam int WideW = (COUNT_WIDTH > ValueWidth) ? COUNT_WIDTH : ValueWidth;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_end;
    logic       in_go;

    // Parse state
    logic r_chain_open, r_locant_pending, r_closure_pending, r_dash_open, r_error_seen;
    logic n_chain_open, n_locant_pending, n_closure_pending, n_dash_open, n_error_seen;
    logic [COUNT_WIDTH-1:0] r_count [NumCounters];
    logic [COUNT_WIDTH-1:0] n_count [NumCounters];
    logic [NumCounters-1:0] bump;
    logic [IdxWidth-1:0]    code;
    logic                   do_close;
    logic [7:0]             c;

    // Snapshot bank and drain
    logic [ValueWidth-1:0] r_shadow [NumCounters];
    logic                  r_shadow_err;
    logic                  r_busy;
    logic [IdxWidth-1:0]   r_drain_idx;
    logic                  load;

    // Output register
    logic                  r_out_valid;
    logic [IdxWidth-1:0]   r_out_index;
    logic [ValueWidth-1:0] r_out_value;
    logic                  r_out_last;
    logic                  r_out_err;

    function automatic logic [ValueWidth-1:0] sat_value(input logic [COUNT_WIDTH-1:0] v);
        logic [WideW-1:0] w;
        w = WideW'(v);
        return (w > WideW'({ValueWidth{1'b1}})) ? {ValueWidth{1'b1}} : w[ValueWidth-1:0];
    endfunction

    // An end item can only take the snapshot bank once the previous run has left it.
    assign in_go         = r_in_valid && !(r_in_end && r_busy);
    assign s_axis_tready = !r_in_valid || in_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (in_go) begin
            r_in_valid <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    always_comb begin
        c                 = r_in_char;
        code              = letter_code(r_in_char);
        do_close          = 1'b0;
        bump              = '0;
        n_chain_open      = r_chain_open;
        n_locant_pending  = r_locant_pending;
        n_closure_pending = r_closure_pending;
        n_dash_open       = r_dash_open;
        n_error_seen      = r_error_seen;
        if (r_in_end) begin
            do_close          = 1'b1;
            n_chain_open      = 1'b0;
            n_locant_pending  = 1'b0;
            n_closure_pending = 1'b0;
            n_dash_open       = 1'b0;
            n_error_seen      = 1'b0;
        end else if (!r_error_seen) begin
            if (c >= CHAR_ONE && c <= CHAR_NINE) begin
                if (!r_closure_pending && !r_dash_open) begin
                    n_chain_open = 1'b1;
                end
            end else if (c == CHAR_ZERO) begin
                if (!r_closure_pending && !r_dash_open) begin
                    n_locant_pending = 1'b0;
                end
            end else if (c == CHAR_J) begin
                do_close = 1'b1;
                if (r_dash_open) begin
                    n_dash_open = r_dash_open;
                end else if (r_locant_pending) begin
                    n_locant_pending = 1'b0;
                end else if (r_closure_pending) begin
                    n_closure_pending = 1'b0;
                    bump[IDX_SCAFF]   = 1'b1;
                end
            end else if (c >= CHAR_A && c <= CHAR_Z) begin
                do_close = 1'b1;
                if (r_closure_pending || r_dash_open) begin
                    n_dash_open = r_dash_open;
                end else if (r_locant_pending) begin
                    n_locant_pending = 1'b0;
                end else if (code == CODE_RING) begin
                    n_closure_pending = 1'b1;
                end else if (code != CODE_NONE) begin
                    bump[code] = 1'b1;
                end
            end else if (c == CHAR_SPACE) begin
                do_close = 1'b1;
                if (r_dash_open) begin
                    n_dash_open      = 1'b0;
                    n_locant_pending = 1'b1;
                end else if (!r_closure_pending) begin
                    n_locant_pending = 1'b1;
                end
            end else if (c == CHAR_AMP || c == CHAR_SLASH) begin
                do_close = 1'b1;
            end else if (c == CHAR_DASH) begin
                do_close = 1'b1;
                if (!r_closure_pending) begin
                    if (r_dash_open) begin
                        n_dash_open     = 1'b0;
                        bump[IDX_OTHER] = 1'b1;
                    end else begin
                        n_dash_open = 1'b1;
                    end
                end
            end else begin
                n_error_seen = 1'b1;
            end
        end
        // Closing a chain is shared by every symbol that ends a run of digits.
        if (do_close && r_chain_open) begin
            if (!r_in_end) begin
                n_chain_open = 1'b0;
            end
            bump[IDX_CHAINS] = 1'b1;
        end
        for (int k = 0; k < NumCounters; k++) begin
            n_count[k] = (bump[k] && (r_count[k] != {COUNT_WIDTH{1'b1}}))
                       ? r_count[k] + COUNT_WIDTH'(1) : r_count[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_open      <= 1'b0;
            r_locant_pending  <= 1'b0;
            r_closure_pending <= 1'b0;
            r_dash_open       <= 1'b0;
            r_error_seen      <= 1'b0;
            for (int k = 0; k < NumCounters; k++) begin
                r_count[k] <= '0;
            end
        end else if (in_go) begin
            r_chain_open      <= n_chain_open;
            r_locant_pending  <= n_locant_pending;
            r_closure_pending <= n_closure_pending;
            r_dash_open       <= n_dash_open;
            r_error_seen      <= n_error_seen;
            for (int k = 0; k < NumCounters; k++) begin
                r_count[k] <= r_in_end ? '0 : n_count[k];
            end
        end
    end

    // Snapshot bank: loaded by an end item, drained one counter per cycle while output can take it.
    assign load = r_busy && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_drain_idx <= '0;
        end else if (in_go && r_in_end) begin
            r_busy      <= 1'b1;
            r_drain_idx <= '0;
        end else if (load) begin
            r_drain_idx <= r_drain_idx + IdxWidth'(1);
            if (r_drain_idx == IDX_SCAFF) begin
                r_busy <= 1'b0;
            end
        end
        if (in_go && r_in_end) begin
            r_shadow_err <= r_error_seen;
            for (int k = 0; k < NumCounters; k++) begin
                r_shadow[k] <= sat_value(n_count[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_out_index <= r_drain_idx;
            r_out_value <= r_shadow[r_drain_idx];
            r_out_last  <= (r_drain_idx == IDX_SCAFF);
            r_out_err   <= r_shadow_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_value, r_out_index};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_err;

    // Only the scaffold counter closes a run.
    a_last_on_scaff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4:0] == IDX_SCAFF)
        else $error("last flag on a counter other than the scaffold count");

    // Counters of one run leave without gaps and in order.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a counter dump");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tdata[4:0] == $past(m_axis_tdata[4:0]) + 5'd1)
        else $error("counter index did not advance by one");

    // The drain pointer never runs past the last counter.
    a_drain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_drain_idx <= IDX_SCAFF)
        else $error("drain index out of range");

endmodule
